[design/brle_pkg.sv]
// Shared types and constants for the byte run-length encoder.
package brle_pkg;

  localparam logic [7:0] MAX_RUN_RESET = 8'hCF;

  // Result queue geometry: holds up to two pairs per pixel plus slack.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic       eoi;
    logic [7:0] length;
    logic [7:0] value;
  } pair_t;

  // Pairs produced by one pixel, packed toward first.
  typedef struct packed {
    pair_t       first;
    pair_t       second;
    logic [1:0]  count;
  } push_t;

endpackage

[design/brle_core.sv]
// Run tracking: open run state, max_run register and pair generation.
module brle_core import brle_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  input  logic [7:0] cfg_data,
  input  logic       accept,
  input  logic [7:0] pixel,
  input  logic       final_pixel,
  output push_t      push
);

  logic [7:0] max_run;
  logic [7:0] open_value;
  logic [7:0] open_count;
  logic       run_active;

  logic [7:0] limit;
  logic       extend;
  logic       close_old;
  logic       close_new;
  logic [7:0] new_value;
  logic [7:0] new_count;
  pair_t      old_pair;
  pair_t      new_pair;

  always_comb begin
    limit     = (max_run == 8'd0) ? 8'd1 : max_run;
    extend    = run_active && (pixel == open_value) && (open_count < limit);
    close_old = run_active && !extend;
    new_value = extend ? open_value : pixel;
    new_count = extend ? open_count + 8'd1 : 8'd1;
    close_new = (new_count >= limit) || final_pixel;

    old_pair = '{eoi: 1'b0, length: open_count, value: open_value};
    new_pair = '{eoi: final_pixel, length: new_count, value: new_value};

    push.first  = close_old ? old_pair : new_pair;
    push.second = new_pair;
    push.count  = accept ? ({1'b0, close_old} + {1'b0, close_new}) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_run    <= MAX_RUN_RESET;
      open_value <= 8'd0;
      open_count <= 8'd0;
      run_active <= 1'b0;
    end else begin
      if (cfg_valid) begin
        max_run <= cfg_data;
      end
      if (accept) begin
        if (close_new) begin
          open_value <= 8'd0;
          open_count <= 8'd0;
          run_active <= 1'b0;
        end else begin
          open_value <= new_value;
          open_count <= new_count;
          run_active <= 1'b1;
        end
      end
    end
  end

  a_active_count: assert property (@(posedge clk) disable iff (rst)
    run_active == (open_count != 8'd0))
    else $error("run_active out of step with open_count");

  a_final_closes: assert property (@(posedge clk) disable iff (rst)
    accept && final_pixel |=> !run_active)
    else $error("run still open after final pixel");

  a_two_not_last_first: assert property (@(posedge clk) disable iff (rst)
    push.count == 2'd2 |-> !push.first.eoi && push.first.length != 8'd0)
    else $error("bad first pair in a double emit");

endmodule

[design/brle_queue.sv]
// Small result queue taking up to two pairs per cycle and giving one.
module brle_queue import brle_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  push_t push,
  output logic  room,
  output logic  out_valid,
  input  logic  out_ready,
  output pair_t head
);

  pair_t             mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              pop;

  assign room      = count <= QCNT_W'(QDEPTH - 2);
  assign out_valid = count != '0;
  assign pop       = out_valid && out_ready;
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + QPTR_W'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push.count);
      rd_ptr <= rd_ptr + QPTR_W'(pop);
      count  <= count + QCNT_W'(push.count) - QCNT_W'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd0 |-> room)
    else $error("push into full queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("queue count beyond depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == '0 || count == QCNT_W'(QDEPTH)) |-> wr_ptr == rd_ptr)
    else $error("pointers disagree with count");

endmodule

[design/byte_run_length_encoder.sv]
// Top level of the byte run-length encoder.
//
// Pixels enter on the s_ stream, one byte per transfer; s_tlast marks the
// last pixel of an image. Runs of equal pixels leave on the m_ stream as
// (value, length) pairs; m_tlast is set on the pair that closes the image.
// A pair is sent when the pixel value changes, when the run reaches max_run
// (a new run then starts, even for the same value) or on the last pixel.
// max_run is written over the cfg channel, which always accepts; a zero acts
// as one. Write it only while the encoder holds no open run or queued pairs.
//
// One pixel is taken per cycle while s_tready is high. A pair is written into
// the queue on the pixel transfer that closes it; a pixel may close two runs,
// and the second pair follows the first on m_. Pairs wait in a four-entry
// queue, and s_tready stays high while two entries are free, so a stalled
// receiver back-pressures the input before the queue can overflow and nothing
// is lost. Reset (synchronous) sets max_run to 207, closes any run and empties
// the queue.
module byte_run_length_encoder import brle_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,  // [7:0] pixel
  input  logic        s_tlast,  // final_pixel
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,  // [7:0] run_value, [15:8] run_length
  output logic        m_tlast   // end_of_image
);

  push_t push;
  pair_t head;
  logic  room;
  logic  accept;

  assign cfg_ready = 1'b1;
  assign s_tready  = room;
  assign accept    = s_tvalid && room;

  brle_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .accept      (accept),
    .pixel       (s_tdata),
    .final_pixel (s_tlast),
    .push        (push)
  );

  brle_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .head      (head)
  );

  assign m_tdata = {head.length, head.value};
  assign m_tlast = head.eoi;

endmodule
